>>> rtl/otpm_pkg.sv
// ---------------------------------------------------------------------------
// OS timing protection monitor package
// Shared request codes, result kinds and the controller command bundle.
// ---------------------------------------------------------------------------
package otpm_pkg;

    localparam int REQ_W   = 4;
    localparam int IDX_W   = 8;
    localparam int TIME_W  = 32;
    localparam int ACT_W   = 2;
    localparam int KIND_W  = 3;
    localparam int CFG_IDX_W = 1;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_TASK_START = 4'd0;
    localparam logic [REQ_W-1:0] REQ_TASK_STOP  = 4'd1;
    localparam logic [REQ_W-1:0] REQ_ARRIVAL    = 4'd2;
    localparam logic [REQ_W-1:0] REQ_RES_LOCK   = 4'd3;
    localparam logic [REQ_W-1:0] REQ_RES_UNLOCK = 4'd4;
    localparam logic [REQ_W-1:0] REQ_AI_LOCK    = 4'd5;
    localparam logic [REQ_W-1:0] REQ_AI_UNLOCK  = 4'd6;
    localparam logic [REQ_W-1:0] REQ_OI_LOCK    = 4'd7;
    localparam logic [REQ_W-1:0] REQ_OI_UNLOCK  = 4'd8;
    localparam logic [REQ_W-1:0] REQ_SCAN       = 4'd9;
    localparam logic [REQ_W-1:0] REQ_CHK_TASK   = 4'd10;
    localparam logic [REQ_W-1:0] REQ_CHK_RES    = 4'd11;
    localparam logic [REQ_W-1:0] REQ_CHK_INTS   = 4'd12;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ARRIVAL  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TASK     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RES      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ALLINT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_OSINT    = 3'd4;

    localparam logic [ACT_W-1:0] ACT_PROT_HOOK = 2'd3;
    localparam logic [ACT_W-1:0] ACT_NONE      = 2'd0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALLINT_BUDGET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OSINT_BUDGET  = 1'd1;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;   // capture the input beat
        logic step;   // run one check or update step
        logic flush;  // release the held result as the last one
    } otpm_cmd_t;

endpackage

>>> rtl/otpm_ctrl.sv
// ---------------------------------------------------------------------------
// OS timing protection monitor controller
// Sequences the steps of one request and paces them against the output.
// ---------------------------------------------------------------------------
module otpm_ctrl
    import otpm_pkg::*;
#(
    parameter int TASK_SLOTS     = 8,
    parameter int RESOURCE_SLOTS = 8,
    parameter int CW             = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [REQ_W-1:0] s_req,
    input  logic             out_free,
    output otpm_cmd_t        cmd,
    output logic [CW-1:0]    step_cnt
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_t;

    localparam logic [CW-1:0] FIRST_INT = CW'(TASK_SLOTS + RESOURCE_SLOTS);
    localparam logic [CW-1:0] LAST_STEP = CW'(TASK_SLOTS + RESOURCE_SLOTS + 1);

    state_t           state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [REQ_W-1:0] req_reg, req_next;
    logic             seq;

    // Scans and interrupt checks walk several steps; everything else is one.
    assign seq = (req_reg == REQ_SCAN) || (req_reg == REQ_CHK_INTS);

    assign s_tready = (state_reg == ST_IDLE);
    assign step_cnt = cnt_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        req_next   = req_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    req_next   = s_req;
                    cnt_next   = (s_req == REQ_CHK_INTS) ? FIRST_INT : '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    cmd.step = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (!seq || cnt_reg == LAST_STEP) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State and sequence registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            req_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            req_reg   <= req_next;
        end
    end

endmodule

>>> rtl/otpm_dpath.sv
// ---------------------------------------------------------------------------
// OS timing protection monitor datapath
// Holds the task, resource and interrupt state, runs one elapsed-time check
// per step and buffers results so the final one can be marked last.
// ---------------------------------------------------------------------------
module otpm_dpath
    import otpm_pkg::*;
#(
    parameter int TASK_SLOTS     = 8,
    parameter int RESOURCE_SLOTS = 8,
    parameter int CW             = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  otpm_cmd_t            cmd,
    input  logic [CW-1:0]        step_cnt,
    input  logic [REQ_W-1:0]     in_req,
    input  logic [IDX_W-1:0]     in_idx,
    input  logic [TIME_W-1:0]    in_now,
    input  logic [TIME_W-1:0]    in_eb,
    input  logic [ACT_W-1:0]     in_fa,
    input  logic [TIME_W-1:0]    in_amin,
    input  logic [TIME_W-1:0]    in_lb,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_wdata,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [KIND_W-1:0]    m_kind,
    output logic [IDX_W-1:0]     m_index,
    output logic [ACT_W-1:0]     m_act,
    output logic                 m_allowed,
    output logic                 m_last,
    output logic                 out_free
);

    localparam int TW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int RW = (RESOURCE_SLOTS > 1) ? $clog2(RESOURCE_SLOTS) : 1;
    localparam logic [CW-1:0] C_T  = CW'(TASK_SLOTS);
    localparam logic [CW-1:0] C_TR = CW'(TASK_SLOTS + RESOURCE_SLOTS);
    localparam logic [CW-1:0] C_LS = CW'(TASK_SLOTS + RESOURCE_SLOTS + 1);

    // Captured request.
    logic [REQ_W-1:0]  req_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TIME_W-1:0] now_reg, eb_reg, amin_reg, lb_reg;
    logic [ACT_W-1:0]  fa_reg;

    // Monitor state.
    logic [TIME_W-1:0] task_start_reg  [TASK_SLOTS];
    logic [TIME_W-1:0] task_limit_reg  [TASK_SLOTS];
    logic [ACT_W-1:0]  task_action_reg [TASK_SLOTS];
    logic [TIME_W-1:0] task_arr_reg    [TASK_SLOTS];
    logic [TASK_SLOTS-1:0]     task_run_reg, task_over_reg;
    logic [TIME_W-1:0] res_start_reg [RESOURCE_SLOTS];
    logic [TIME_W-1:0] res_limit_reg [RESOURCE_SLOTS];
    logic [RESOURCE_SLOTS-1:0] res_locked_reg;
    logic [TIME_W-1:0] ai_start_reg, oi_start_reg, ai_budget_reg, oi_budget_reg;
    logic              ai_locked_reg, oi_locked_reg;

    // Result buffering.
    logic              hold_v_reg, mv_reg;
    logic [KIND_W-1:0] hold_kind_reg;
    logic [IDX_W-1:0]  hold_idx_reg;
    logic [ACT_W-1:0]  hold_act_reg;
    logic              hold_ok_reg;

    logic              seq, task_in, res_in;
    logic [TW-1:0]     ta;
    logic [RW-1:0]     ra;
    logic              chk_task, chk_res, chk_ai, chk_oi;
    logic [TIME_W-1:0] el_task, el_res, el_ai, el_oi, el_arr;
    logic              f_task, f_res, f_ai, f_oi, arr_ok;
    logic              cand_v, cand_ok;
    logic [KIND_W-1:0] cand_kind;
    logic [IDX_W-1:0]  cand_idx;
    logic [ACT_W-1:0]  cand_act;

    assign seq     = (req_reg == REQ_SCAN) || (req_reg == REQ_CHK_INTS);
    assign task_in = (idx_reg < IDX_W'(TASK_SLOTS));
    assign res_in  = (idx_reg < IDX_W'(RESOURCE_SLOTS));

    // Entry addresses: the step count during a scan, the target otherwise.
    assign ta = (req_reg == REQ_SCAN) ? step_cnt[TW-1:0] : idx_reg[TW-1:0];
    always_comb begin
        logic [CW-1:0] roff;
        roff = step_cnt - C_T;
        ra = (req_reg == REQ_SCAN) ? roff[RW-1:0] : idx_reg[RW-1:0];
    end

    // Which check this step performs.
    assign chk_task = seq ? ((req_reg == REQ_SCAN) && (step_cnt < C_T))
                          : ((req_reg == REQ_CHK_TASK) && task_in);
    assign chk_res  = seq ? ((req_reg == REQ_SCAN) && (step_cnt >= C_T)
                             && (step_cnt < C_TR))
                          : ((req_reg == REQ_CHK_RES) && res_in);
    assign chk_ai   = seq && (step_cnt == C_TR);
    assign chk_oi   = seq && (step_cnt == C_LS);

    // Wrapping elapsed times and budget compares.
    assign el_task = now_reg - task_start_reg[ta];
    assign el_res  = now_reg - res_start_reg[ra];
    assign el_ai   = now_reg - ai_start_reg;
    assign el_oi   = now_reg - oi_start_reg;
    assign el_arr  = now_reg - task_arr_reg[ta];
    assign f_task  = chk_task && task_run_reg[ta] && (el_task > task_limit_reg[ta]);
    assign f_res   = chk_res && res_locked_reg[ra] && (el_res > res_limit_reg[ra]);
    assign f_ai    = chk_ai && ai_locked_reg && (el_ai > ai_budget_reg);
    assign f_oi    = chk_oi && oi_locked_reg && (el_oi > oi_budget_reg);
    assign arr_ok  = !task_in || (task_arr_reg[ta] == '0) || !(el_arr < amin_reg);

    // Candidate result of this step.
    always_comb begin
        cand_v    = 1'b0;
        cand_kind = KIND_ARRIVAL;
        cand_idx  = '0;
        cand_act  = ACT_NONE;
        cand_ok   = 1'b0;
        if (!seq && req_reg == REQ_ARRIVAL) begin
            cand_v   = 1'b1;
            cand_idx = idx_reg;
            cand_ok  = arr_ok;
        end else if (f_task) begin
            cand_v    = 1'b1;
            cand_kind = KIND_TASK;
            cand_idx  = IDX_W'(ta);
            cand_act  = task_action_reg[ta];
        end else if (f_res) begin
            cand_v    = 1'b1;
            cand_kind = KIND_RES;
            cand_idx  = IDX_W'(ra);
            cand_act  = ACT_PROT_HOOK;
        end else if (f_ai) begin
            cand_v    = 1'b1;
            cand_kind = KIND_ALLINT;
            cand_act  = ACT_PROT_HOOK;
        end else if (f_oi) begin
            cand_v    = 1'b1;
            cand_kind = KIND_OSINT;
            cand_act  = ACT_PROT_HOOK;
        end
    end

    // Request capture and wide state, no reset needed.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_reg  <= in_idx;
            now_reg  <= in_now;
            eb_reg   <= in_eb;
            fa_reg   <= in_fa;
            amin_reg <= in_amin;
            lb_reg   <= in_lb;
        end
        if (cmd.step && !seq) begin
            if (req_reg == REQ_TASK_START && task_in) begin
                task_start_reg[ta]  <= now_reg;
                task_limit_reg[ta]  <= eb_reg;
                task_action_reg[ta] <= fa_reg;
            end
            if (req_reg == REQ_RES_LOCK && res_in) begin
                res_start_reg[ra] <= now_reg;
                res_limit_reg[ra] <= lb_reg;
            end
        end
    end

    // Control state, marks, arrival times and budgets.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg        <= '0;
            task_run_reg   <= '0;
            task_over_reg  <= '0;
            res_locked_reg <= '0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                task_arr_reg[i] <= '0;
            end
            ai_start_reg   <= '0;
            oi_start_reg   <= '0;
            ai_locked_reg  <= 1'b0;
            oi_locked_reg  <= 1'b0;
            ai_budget_reg  <= '1;
            oi_budget_reg  <= '1;
        end else begin
            if (cmd.load) begin
                req_reg <= in_req;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ALLINT_BUDGET: ai_budget_reg <= cfg_wdata;
                    CFG_OSINT_BUDGET:  oi_budget_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.step) begin
                if (f_task) begin
                    task_over_reg[ta] <= 1'b1;
                end
                if (!seq) begin
                    case (req_reg)
                        REQ_TASK_START: if (task_in) begin
                            task_run_reg[ta]  <= 1'b1;
                            task_over_reg[ta] <= 1'b0;
                        end
                        REQ_TASK_STOP: if (task_in) begin
                            task_run_reg[ta] <= 1'b0;
                        end
                        REQ_ARRIVAL: if (task_in && arr_ok) begin
                            task_arr_reg[ta] <= now_reg;
                        end
                        REQ_RES_LOCK: if (res_in) begin
                            res_locked_reg[ra] <= 1'b1;
                        end
                        REQ_RES_UNLOCK: if (res_in) begin
                            res_locked_reg[ra] <= 1'b0;
                        end
                        REQ_AI_LOCK: begin
                            ai_start_reg  <= now_reg;
                            ai_locked_reg <= 1'b1;
                        end
                        REQ_AI_UNLOCK: ai_locked_reg <= 1'b0;
                        REQ_OI_LOCK: begin
                            oi_start_reg  <= now_reg;
                            oi_locked_reg <= 1'b1;
                        end
                        REQ_OI_UNLOCK: oi_locked_reg <= 1'b0;
                        default: ;
                    endcase
                end
            end
        end
    end

    // One result is held back until the next one, or the end, shows
    // whether it is the last of the request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            // The output beat is loaded when the held result moves out,
            // otherwise it clears once the receiver takes it.
            if (hold_v_reg && ((cmd.step && cand_v) || cmd.flush)) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
            if (cmd.step && cand_v) begin
                if (hold_v_reg) begin
                    m_kind    <= hold_kind_reg;
                    m_index   <= hold_idx_reg;
                    m_act     <= hold_act_reg;
                    m_allowed <= hold_ok_reg;
                    m_last    <= 1'b0;
                end
                hold_v_reg    <= 1'b1;
                hold_kind_reg <= cand_kind;
                hold_idx_reg  <= cand_idx;
                hold_act_reg  <= cand_act;
                hold_ok_reg   <= cand_ok;
            end else if (cmd.flush && hold_v_reg) begin
                m_kind     <= hold_kind_reg;
                m_index    <= hold_idx_reg;
                m_act      <= hold_act_reg;
                m_allowed  <= hold_ok_reg;
                m_last     <= 1'b1;
                hold_v_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = mv_reg;
    assign out_free = !mv_reg || m_tready;

endmodule

>>> rtl/os_timing_protection_monitor.sv
// ---------------------------------------------------------------------------
// OS timing protection monitor
// Checks task execution, interarrival, resource lock and interrupt lock
// times against their budgets and reports verdicts and faults.
// ---------------------------------------------------------------------------
// One event is taken at a time. A single event runs a load, one step and a
// release; an interrupt check runs a step per interrupt lock, and a scan one
// step per task, resource and interrupt entry, visiting one entry per cycle
// while the output is free; output stalls hold the steps. Results of one
// event come out in order and the last one carries tlast. No clearing pass
// is needed after reset.
module os_timing_protection_monitor
    import otpm_pkg::*;
#(
    parameter int TASK_SLOTS     = 8,
    parameter int RESOURCE_SLOTS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // target_index[7:0], now_us[39:8], exec_budget[71:40],
    // fault_action_in[73:72], arrival_min[105:74], lock_budget[137:106]
    input  logic [143:0]         s_tdata,
    // req_type[3:0]
    input  logic [REQ_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_index[7:0], action_code[9:8], activation_allowed[10]
    output logic [15:0]          m_tdata,
    // result_kind[2:0]
    output logic [KIND_W-1:0]    m_tuser,
    output logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_wdata
);

    localparam int CW = $clog2(TASK_SLOTS + RESOURCE_SLOTS + 2);

    otpm_cmd_t         cmd;
    logic [CW-1:0]     step_cnt;
    logic              out_free;
    logic [IDX_W-1:0]  m_index;
    logic [ACT_W-1:0]  m_act;
    logic              m_allowed;

    otpm_ctrl #(
        .TASK_SLOTS     (TASK_SLOTS),
        .RESOURCE_SLOTS (RESOURCE_SLOTS),
        .CW             (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_req    (s_tuser),
        .out_free (out_free),
        .cmd      (cmd),
        .step_cnt (step_cnt)
    );

    otpm_dpath #(
        .TASK_SLOTS     (TASK_SLOTS),
        .RESOURCE_SLOTS (RESOURCE_SLOTS),
        .CW             (CW)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .step_cnt  (step_cnt),
        .in_req    (s_tuser),
        .in_idx    (s_tdata[7:0]),
        .in_now    (s_tdata[39:8]),
        .in_eb     (s_tdata[71:40]),
        .in_fa     (s_tdata[73:72]),
        .in_amin   (s_tdata[105:74]),
        .in_lb     (s_tdata[137:106]),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_kind    (m_tuser),
        .m_index   (m_index),
        .m_act     (m_act),
        .m_allowed (m_allowed),
        .m_last    (m_tlast),
        .out_free  (out_free)
    );

    assign m_tdata = {5'd0, m_allowed, m_act, m_index};

endmodule

>>> tb/otpm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// OS timing protection monitor checker
// Watches the event and result streams and the register port, keeps its own
// copy of the task, resource and interrupt lock tables, predicts the
// verdict and fault beats of each event, and compares them in order.
// ---------------------------------------------------------------------------
module otpm_checker
    import otpm_pkg::*;
#(
    parameter int TASK_SLOTS     = 8,
    parameter int RESOURCE_SLOTS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [143:0]         s_tdata,
    input  logic [REQ_W-1:0]     s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [15:0]          m_tdata,
    input  logic [KIND_W-1:0]    m_tuser,
    input  logic                 m_tlast,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_wdata,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  index;
        logic [ACT_W-1:0]  action;
        logic              allowed;
        logic              last;
    } fault_beat_t;

    fault_beat_t expected_beats[$];

    // Shadow state of the monitor.
    logic [31:0] t_start [TASK_SLOTS];
    logic        t_run   [TASK_SLOTS];
    logic [31:0] t_limit [TASK_SLOTS];
    logic [1:0]  t_act   [TASK_SLOTS];
    logic [31:0] t_arr   [TASK_SLOTS];
    logic [31:0] r_start [RESOURCE_SLOTS];
    logic [31:0] r_limit [RESOURCE_SLOTS];
    logic        r_held  [RESOURCE_SLOTS];
    logic [31:0] ai_start, oi_start, ai_budget, oi_budget;
    logic        ai_held, oi_held;

    assign pending = expected_beats.size();

    task automatic push_beat(input logic [KIND_W-1:0] k, input int idx,
                             input logic [1:0] act, input logic ok);
        fault_beat_t b;
        b.kind = k; b.index = idx[7:0]; b.action = act; b.allowed = ok; b.last = 1'b0;
        expected_beats.push_back(b);
    endtask

    task automatic check_task_entry(input int t, input logic [31:0] now);
        if (t < TASK_SLOTS && t_run[t] && (now - t_start[t]) > t_limit[t])
            push_beat(KIND_TASK, t, t_act[t], 1'b0);
    endtask

    task automatic check_res_entry(input int r, input logic [31:0] now);
        if (r < RESOURCE_SLOTS && r_held[r] && (now - r_start[r]) > r_limit[r])
            push_beat(KIND_RES, r, ACT_PROT_HOOK, 1'b0);
    endtask

    task automatic check_int_locks(input logic [31:0] now);
        if (ai_held && (now - ai_start) > ai_budget)
            push_beat(KIND_ALLINT, 0, ACT_PROT_HOOK, 1'b0);
        if (oi_held && (now - oi_start) > oi_budget)
            push_beat(KIND_OSINT, 0, ACT_PROT_HOOK, 1'b0);
    endtask

    // Apply one accepted event to the shadow state and queue its results.
    task automatic predict_event(input logic [REQ_W-1:0] req, input logic [143:0] d);
        int idx, n0;
        logic [31:0] now, amin;
        logic ok;
        idx = d[7:0];
        now = d[39:8];
        amin = d[105:74];
        n0 = expected_beats.size();
        case (req)
            REQ_TASK_START: if (idx < TASK_SLOTS) begin
                t_start[idx] = now; t_run[idx] = 1'b1;
                t_limit[idx] = d[71:40]; t_act[idx] = d[73:72];
            end
            REQ_TASK_STOP: if (idx < TASK_SLOTS) t_run[idx] = 1'b0;
            REQ_ARRIVAL: begin
                ok = 1'b1;
                if (idx < TASK_SLOTS) begin
                    if (t_arr[idx] != 0 && (now - t_arr[idx]) < amin) ok = 1'b0;
                    else t_arr[idx] = now;
                end
                push_beat(KIND_ARRIVAL, idx, ACT_NONE, ok);
            end
            REQ_RES_LOCK: if (idx < RESOURCE_SLOTS) begin
                r_start[idx] = now; r_limit[idx] = d[137:106]; r_held[idx] = 1'b1;
            end
            REQ_RES_UNLOCK: if (idx < RESOURCE_SLOTS) r_held[idx] = 1'b0;
            REQ_AI_LOCK: begin ai_start = now; ai_held = 1'b1; end
            REQ_AI_UNLOCK: ai_held = 1'b0;
            REQ_OI_LOCK: begin oi_start = now; oi_held = 1'b1; end
            REQ_OI_UNLOCK: oi_held = 1'b0;
            REQ_SCAN: begin
                for (int i = 0; i < TASK_SLOTS; i++) check_task_entry(i, now);
                for (int i = 0; i < RESOURCE_SLOTS; i++) check_res_entry(i, now);
                check_int_locks(now);
            end
            REQ_CHK_TASK: check_task_entry(idx, now);
            REQ_CHK_RES: check_res_entry(idx, now);
            REQ_CHK_INTS: check_int_locks(now);
            default: ;
        endcase
        if (expected_beats.size() > n0)
            expected_beats[expected_beats.size()-1].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        fault_beat_t got, exp_b;
        if (!aresetn) begin
            for (int i = 0; i < TASK_SLOTS; i++) begin
                t_run[i] = 1'b0; t_arr[i] = '0;
            end
            for (int i = 0; i < RESOURCE_SLOTS; i++) r_held[i] = 1'b0;
            ai_held = 1'b0; oi_held = 1'b0;
            ai_budget = '1; oi_budget = '1;
            expected_beats.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_ALLINT_BUDGET) ai_budget = cfg_wdata;
                else oi_budget = cfg_wdata;
            end
            // Compare the result beat before queueing anything new.
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[10], m_tlast};
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    fail_count++;
                end else begin
                    exp_b = expected_beats.pop_front();
                    if (got != exp_b) begin
                        $display("%0t: result mismatch expected kind %0d idx %0d act %0d ok %0d last %0d, actual kind %0d idx %0d act %0d ok %0d last %0d",
                                 $time, exp_b.kind, exp_b.index, exp_b.action, exp_b.allowed,
                                 exp_b.last, got.kind, got.index, got.action, got.allowed,
                                 got.last);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) predict_event(s_tuser, s_tdata);
        end
    end

endmodule

>>> tb/tb_os_timing_protection_monitor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// OS timing protection monitor testbench
// Drives directed and random timing events with random gaps on both sides,
// writes the interrupt lock budgets between phases, and reports the verdict.
// ---------------------------------------------------------------------------
module tb_os_timing_protection_monitor;
    import otpm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [143:0]         s_tdata = '0;
    logic [REQ_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;
    logic [KIND_W-1:0]    m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_wdata = '0;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles = 0;
    bit                   hold_off = 1'b0;
    logic [31:0]          clock_us = 32'd100;

    always #1 aclk = ~aclk;

    os_timing_protection_monitor dut (.*);

    otpm_checker checker_i (.*);

    // Watchdog: cycles with no beat on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(5, 30);
    endfunction

    // Receiver: random stalls, and one long hold-off on request.
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end
            n = $urandom_range(0, 3) == 0 ? gap_len() : 0;
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_event(input logic [REQ_W-1:0] req, input logic [7:0] idx,
                              input logic [31:0] now, input logic [31:0] eb,
                              input logic [1:0] fa, input logic [31:0] amin,
                              input logic [31:0] lb, input bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {6'd0, lb, amin, fa, eb, now, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic end_phase();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random event biased toward small indices and short time steps.
    task automatic random_event(input bit gaps);
        logic [REQ_W-1:0] req;
        logic [7:0] idx;
        req = ($urandom_range(0, 19) == 0) ? REQ_W'($urandom_range(13, 15))
                                           : REQ_W'($urandom_range(0, 12));
        idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        if ($urandom_range(0, 15) == 0) clock_us = $urandom;
        else clock_us = clock_us + $urandom_range(0, 400);
        send_event(req, idx, clock_us,
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 500),
                   2'($urandom),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 500),
                   $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 500), gaps);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, each request, wrap, idle checks, arrival at zero.
        write_reg(CFG_ALLINT_BUDGET, 32'd0);
        write_reg(CFG_OSINT_BUDGET, 32'hFFFF_FFFF);
        send_event(REQ_CHK_TASK, 8'd0, 32'd5, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_TASK_START, 8'd0, 32'hFFFF_FFF0, 32'd10, 2'd3, 32'd0, 32'd0, 1'b1);
        send_event(REQ_TASK_START, 8'd7, 32'd0, 32'hFFFF_FFFF, 2'd1, 32'd0, 32'd0, 1'b1);
        send_event(REQ_TASK_START, 8'd200, 32'd0, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_CHK_TASK, 8'd0, 32'd20, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_ARRIVAL, 8'd3, 32'd0, 32'd0, 2'd0, 32'hFFFF_FFFF, 32'd0, 1'b1);
        send_event(REQ_ARRIVAL, 8'd3, 32'd1, 32'd0, 2'd0, 32'hFFFF_FFFF, 32'd0, 1'b1);
        send_event(REQ_ARRIVAL, 8'd3, 32'd50, 32'd0, 2'd0, 32'd100, 32'd0, 1'b1);
        send_event(REQ_ARRIVAL, 8'd3, 32'd60, 32'd0, 2'd0, 32'd100, 32'd0, 1'b1);
        send_event(REQ_ARRIVAL, 8'd255, 32'd60, 32'd0, 2'd0, 32'd100, 32'd0, 1'b1);
        send_event(REQ_RES_LOCK, 8'd5, 32'd100, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_RES_LOCK, 8'd9, 32'd100, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_CHK_RES, 8'd5, 32'd101, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_AI_LOCK, 8'd0, 32'd100, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_OI_LOCK, 8'd0, 32'd100, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_CHK_INTS, 8'd0, 32'd99, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_SCAN, 8'd0, 32'd500, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_SCAN, 8'd0, 32'd600, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_TASK_STOP, 8'd0, 32'd700, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_RES_UNLOCK, 8'd5, 32'd700, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_AI_UNLOCK, 8'd0, 32'd700, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_OI_UNLOCK, 8'd0, 32'd700, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(4'd15, 8'd0, 32'd700, 32'd0, 2'd0, 32'd0, 32'd0, 1'b1);
        send_event(REQ_CHK_RES, 8'd5, 32'd900, '1, '1, '1, '1, 1'b1);
        end_phase();

        // Random phases with different budgets; the first has no gaps on input.
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_ALLINT_BUDGET, ph == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 600));
            write_reg(CFG_OSINT_BUDGET, ph == 3 ? 32'd0 : $urandom_range(0, 600));
            // Fill every slot so scans give long result bursts.
            for (int i = 0; i < 8; i++) begin
                send_event(REQ_TASK_START, i[7:0], clock_us, $urandom_range(0, 200),
                           2'(i), 32'd0, 32'd0, ph != 0);
                send_event(REQ_RES_LOCK, i[7:0], clock_us, 32'd0, 2'd0, 32'd0,
                           $urandom_range(0, 200), ph != 0);
            end
            if (ph == 2) hold_off = 1'b1;
            for (int k = 0; k < 8; k++) random_event(ph != 0);
            end_phase();
        end

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
